// ===== rtl/rbb_pkg.sv =====
`default_nettype none

package rbb_pkg;

	localparam int ROW_BITS_W    = 16;
	localparam int COL_W         = 5;
	localparam int ADDR_W        = 5;
	localparam int DATA_W        = 32;
	localparam int DEF_MAX_WIDTH = 16;

	localparam logic [7:0] RST_ORIGIN_X = 8'd0;
	localparam logic [7:0] RST_ORIGIN_Y = 8'd0;
	localparam logic [4:0] RST_WIDTH    = 5'd8;
	localparam logic [7:0] RST_HEIGHT   = 8'd8;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X      = 3'd0,
		REG_ORIGIN_Y      = 3'd1,
		REG_BITMAP_WIDTH  = 3'd2,
		REG_BITMAP_HEIGHT = 3'd3,
		REG_ROTATION      = 3'd4
	} reg_idx_t;

	typedef enum logic {
		SCAN_IDLE = 1'b0,
		SCAN_RUN  = 1'b1
	} scan_state_t;

	typedef struct packed {
		logic [7:0]  row_index;
		logic [15:0] row_bits;
	} row_item_t;

	typedef struct packed {
		logic [8:0] pixel_x;
		logic [8:0] pixel_y;
		logic       last_pixel;
	} pixel_item_t;

	typedef struct packed {
		logic [7:0] origin_x;
		logic [7:0] origin_y;
		logic [4:0] bitmap_width;
		logic [7:0] bitmap_height;
		rot_t       rotation;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] pos;
		logic [7:0]       row;
	} coord_req_t;

	typedef struct packed {
		logic busy;
		logic live;
	} scan_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rbb_regs.sv =====
`default_nettype none

module rbb_regs (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [rbb_pkg::ADDR_W-1:0]   paddr,
	input  wire [rbb_pkg::DATA_W-1:0]   pwdata,
	output logic [rbb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output rbb_pkg::cfg_t               cfg
);
	import rbb_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x      <= RST_ORIGIN_X;
			cfg_q.origin_y      <= RST_ORIGIN_Y;
			cfg_q.bitmap_width  <= RST_WIDTH;
			cfg_q.bitmap_height <= RST_HEIGHT;
			cfg_q.rotation      <= ROT_0;
		end else if (wr_en) begin
			case (idx)
				REG_ORIGIN_X:      cfg_q.origin_x      <= pwdata[7:0];
				REG_ORIGIN_Y:      cfg_q.origin_y      <= pwdata[7:0];
				REG_BITMAP_WIDTH:  cfg_q.bitmap_width  <= pwdata[4:0];
				REG_BITMAP_HEIGHT: cfg_q.bitmap_height <= pwdata[7:0];
				REG_ROTATION:      cfg_q.rotation      <= rot_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ORIGIN_X:      prdata = {24'd0, cfg_q.origin_x};
			REG_ORIGIN_Y:      prdata = {24'd0, cfg_q.origin_y};
			REG_BITMAP_WIDTH:  prdata = {27'd0, cfg_q.bitmap_width};
			REG_BITMAP_HEIGHT: prdata = {24'd0, cfg_q.bitmap_height};
			REG_ROTATION:      prdata = {30'd0, cfg_q.rotation};
			default:           prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/rbb_coord.sv =====
`default_nettype none

module rbb_coord (
	input  wire rbb_pkg::cfg_t       cfg,
	input  wire rbb_pkg::coord_req_t req,
	output logic [8:0]               pixel_x,
	output logic [8:0]               pixel_y
);
	import rbb_pkg::*;

	logic [7:0] flip_row;
	logic [7:0] rx;
	logic [7:0] ry;

	// The row index is known to lie below the height, so this never wraps.
	assign flip_row = 8'(cfg.bitmap_height - 8'd1 - req.row);

	always_comb begin
		case (cfg.rotation)
			ROT_90: begin
				rx = req.row;
				ry = 8'(req.pos);
			end
			ROT_180: begin
				rx = 8'(req.pos);
				ry = flip_row;
			end
			ROT_270: begin
				rx = flip_row;
				ry = 8'(req.col);
			end
			default: begin
				rx = 8'(req.col);
				ry = req.row;
			end
		endcase
	end

	assign pixel_x = {1'b0, cfg.origin_x} + {1'b0, rx};
	assign pixel_y = {1'b0, cfg.origin_y} + {1'b0, ry};

endmodule

`default_nettype wire

// ===== rtl/rbb_scan.sv =====
`default_nettype none

module rbb_scan #(
	parameter int MAX_WIDTH = rbb_pkg::DEF_MAX_WIDTH
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire rbb_pkg::cfg_t       cfg,
	input  wire                      row_valid,
	output logic                     row_stall,
	input  wire rbb_pkg::row_item_t  row,
	output rbb_pkg::coord_req_t      req,
	input  wire [8:0]                map_x,
	input  wire [8:0]                map_y,
	output logic                     pixel_valid,
	input  wire                      pixel_stall,
	output rbb_pkg::pixel_item_t     pixel,
	output rbb_pkg::scan_stat_t      stat
);
	import rbb_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	scan_state_t           state_q;
	scan_state_t           state_d;
	logic [CW-1:0]         col_q;
	logic [7:0]            row_q;
	logic [ROW_BITS_W-1:0] eff_q;
	logic                  out_valid_q;
	pixel_item_t           out_q;

	logic                  width_ok;
	logic                  row_ok;
	logic [ROW_BITS_W-1:0] in_eff;
	logic [ROW_BITS_W-1:0] rest;
	logic                  take;
	logic                  start;
	logic [COL_W-1:0]      col5;
	logic [COL_W-1:0]      pos;
	logic                  lit;
	logic                  rest_zero;
	logic                  can_load;
	logic                  step;

	assign width_ok = (cfg.bitmap_width != '0) &&
		(32'(cfg.bitmap_width) <= 32'(MAX_WIDTH));
	assign row_ok   = (cfg.bitmap_height != '0) && (row.row_index < cfg.bitmap_height);

	// Only bit positions below the width map to a column of the row.
	always_comb begin
		for (int i = 0; i < ROW_BITS_W; i++) begin
			in_eff[i] = row.row_bits[i] && (COL_W'(i) < cfg.bitmap_width);
		end
	end

	assign take  = row_valid && !row_stall;
	assign start = take && width_ok && row_ok && (|in_eff);

	assign col5 = COL_W'(col_q);
	assign pos  = COL_W'(cfg.bitmap_width - 5'd1 - col5);
	assign lit  = (pos < COL_W'(ROW_BITS_W)) && eff_q[pos[3:0]];

	always_comb begin
		for (int i = 0; i < ROW_BITS_W; i++) begin
			rest[i] = eff_q[i] && (COL_W'(i) < pos);
		end
	end

	assign rest_zero = ~|rest;
	assign can_load  = !out_valid_q || !pixel_stall;
	assign step      = (state_q == SCAN_RUN) && can_load;

	always_comb begin
		state_d   = state_q;
		row_stall = 1'b1;
		case (state_q)
			SCAN_IDLE: begin
				row_stall = 1'b0;
				if (start) begin
					state_d = SCAN_RUN;
				end
			end
			SCAN_RUN: begin
				if (step && lit && rest_zero) begin
					state_d = SCAN_IDLE;
				end
			end
			default: state_d = SCAN_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SCAN_IDLE;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				col_q <= '0;
			end else if (step) begin
				col_q <= col_q + CW'(1);
			end
			if (step && lit) begin
				out_valid_q <= 1'b1;
			end else if (!pixel_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_q <= row.row_index;
			eff_q <= in_eff;
		end
		if (step && lit) begin
			out_q.pixel_x    <= map_x;
			out_q.pixel_y    <= map_y;
			out_q.last_pixel <= rest_zero;
		end
	end

	assign req.col     = col5;
	assign req.pos     = pos;
	assign req.row     = row_q;
	assign pixel_valid = out_valid_q;
	assign pixel       = out_q;
	assign stat.busy   = (state_q == SCAN_RUN);
	assign stat.live   = lit || !rest_zero;

endmodule

`default_nettype wire

// ===== rtl/rotated_bitmap_row_blit_unit.sv =====
`default_nettype none

// Rotated bitmap row blitter. Each accepted row word yields one pixel word per lit column,
// in ascending column order, with last_pixel set on the final one; rows with an invalid
// width, a zero height, an index at or past the height, or no lit column yield nothing.
// A row is scanned by a single column counter that feeds one shared rotate-and-offset
// unit, one column per cycle unless the pixel side stalls; row_stall stays high until
// the last lit column is taken. Rows that yield nothing are taken without a scan.
// The user must write the registers over the APB port only while no row is in flight;
// the block itself does not enforce this.
module rotated_bitmap_row_blit_unit #(
	parameter int MAX_WIDTH = rbb_pkg::DEF_MAX_WIDTH
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [rbb_pkg::ADDR_W-1:0]   paddr,
	input  wire [rbb_pkg::DATA_W-1:0]   pwdata,
	output logic [rbb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  wire                         row_valid,
	output logic                        row_stall,
	input  wire rbb_pkg::row_item_t     row,
	output logic                        pixel_valid,
	input  wire                         pixel_stall,
	output rbb_pkg::pixel_item_t        pixel
);
	import rbb_pkg::*;

	cfg_t       cfg;
	coord_req_t req;
	scan_stat_t stat;
	logic [8:0] map_x;
	logic [8:0] map_y;
	logic       width_bad;

	rbb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbb_coord u_coord (
		.cfg     (cfg),
		.req     (req),
		.pixel_x (map_x),
		.pixel_y (map_y)
	);

	rbb_scan #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.row_valid   (row_valid),
		.row_stall   (row_stall),
		.row         (row),
		.req         (req),
		.map_x       (map_x),
		.map_y       (map_y),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.stat        (stat)
	);

	assign width_bad = (cfg.bitmap_width == '0) ||
		(32'(cfg.bitmap_width) > 32'(MAX_WIDTH));

	// A row with a bad width must never start a scan.
	a_bad_width_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && !row_stall && width_bad) |=> !stat.busy)
		else $error("scan started on a row with an invalid width");

	// While scanning, at least one lit column must remain at or after the current one.
	a_busy_live: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> stat.live)
		else $error("scan running with no lit column left");

	// A scan begins only on an accepted row.
	a_start_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.busy) |-> $past(row_valid && !row_stall))
		else $error("scan began without an accepted row");

endmodule

`default_nettype wire

// ===== tb/rbb_checker.sv =====
`timescale 1ns / 100ps

module rbb_checker #(
	parameter int MAX_WIDTH = rbb_pkg::DEF_MAX_WIDTH
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [rbb_pkg::ADDR_W-1:0]    paddr,
	input  wire [rbb_pkg::DATA_W-1:0]    pwdata,
	input  wire [rbb_pkg::DATA_W-1:0]    prdata,
	input  wire                          pready,
	input  wire                          row_valid,
	input  wire                          row_stall,
	input  rbb_pkg::row_item_t           row,
	input  wire                          pixel_valid,
	input  wire                          pixel_stall,
	input  rbb_pkg::pixel_item_t         pixel,
	output int                           pixels_due,
	output int                           fail_count
);
	import rbb_pkg::*;

	localparam int MAX_REPORTS = 40;

	cfg_t        shadow;
	pixel_item_t pixel_fifo[$];

	// Queues the pixel words one row word should produce under the current settings.
	function automatic void predict_row(input row_item_t r);
		int          w, h, pos, last_col, rx, ry;
		pixel_item_t p;
		w = shadow.bitmap_width;
		h = shadow.bitmap_height;
		if (w == 0 || w > MAX_WIDTH || h == 0 || r.row_index >= h)
			return;
		last_col = -1;
		for (int col = 0; col < w; col++) begin
			pos = w - 1 - col;
			if (pos < ROW_BITS_W && r.row_bits[pos])
				last_col = col;
		end
		for (int col = 0; col <= last_col; col++) begin
			pos = w - 1 - col;
			if (pos >= ROW_BITS_W || !r.row_bits[pos])
				continue;
			case (shadow.rotation)
				ROT_90: begin
					rx = r.row_index;
					ry = w - 1 - col;
				end
				ROT_180: begin
					rx = w - 1 - col;
					ry = h - 1 - r.row_index;
				end
				ROT_270: begin
					rx = h - 1 - r.row_index;
					ry = col;
				end
				default: begin
					rx = col;
					ry = r.row_index;
				end
			endcase
			p.pixel_x    = 9'(shadow.origin_x + rx);
			p.pixel_y    = 9'(shadow.origin_y + ry);
			p.last_pixel = (col == last_col);
			pixel_fifo.push_back(p);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		logic [DATA_W-1:0] want;
		bit                known;
		pixel_item_t       exp_px;
		if (!arst_n) begin
			shadow.origin_x      = RST_ORIGIN_X;
			shadow.origin_y      = RST_ORIGIN_Y;
			shadow.bitmap_width  = RST_WIDTH;
			shadow.bitmap_height = RST_HEIGHT;
			shadow.rotation      = ROT_0;
			pixel_fifo.delete();
		end else begin
			if (psel && penable && pready) begin
				known = (paddr[1:0] == 2'b00);
				want  = '0;
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_ORIGIN_X: begin
						if (pwrite && known) shadow.origin_x = pwdata[7:0];
						want = DATA_W'(shadow.origin_x);
					end
					REG_ORIGIN_Y: begin
						if (pwrite && known) shadow.origin_y = pwdata[7:0];
						want = DATA_W'(shadow.origin_y);
					end
					REG_BITMAP_WIDTH: begin
						if (pwrite && known) shadow.bitmap_width = pwdata[4:0];
						want = DATA_W'(shadow.bitmap_width);
					end
					REG_BITMAP_HEIGHT: begin
						if (pwrite && known) shadow.bitmap_height = pwdata[7:0];
						want = DATA_W'(shadow.bitmap_height);
					end
					REG_ROTATION: begin
						if (pwrite && known) shadow.rotation = rot_t'(pwdata[1:0]);
						want = DATA_W'(shadow.rotation);
					end
					default: known = 1'b0;
				endcase
				if (!pwrite && known && prdata !== want) begin
					if (fail_count < MAX_REPORTS)
						$display("%0t: register read at 0x%0h: expected 0x%0h, got 0x%0h",
							$time, paddr, want, prdata);
					fail_count++;
				end
			end

			if (row_valid && !row_stall)
				predict_row(row);

			if (pixel_valid && !pixel_stall) begin
				if (pixel_fifo.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("%0t: pixel word with none expected: expected nothing, got x=%0d y=%0d last=%0b",
							$time, pixel.pixel_x, pixel.pixel_y, pixel.last_pixel);
					fail_count++;
				end else begin
					exp_px = pixel_fifo.pop_front();
					if (pixel.pixel_x !== exp_px.pixel_x || pixel.pixel_y !== exp_px.pixel_y ||
					    pixel.last_pixel !== exp_px.last_pixel) begin
						if (fail_count < MAX_REPORTS)
							$display("%0t: pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
								$time, exp_px.pixel_x, exp_px.pixel_y, exp_px.last_pixel,
								pixel.pixel_x, pixel.pixel_y, pixel.last_pixel);
						fail_count++;
					end
				end
			end
		end
		pixels_due = pixel_fifo.size();
	end

endmodule

// ===== tb/rotated_bitmap_row_blit_unit_tb.sv =====
`timescale 1ns / 100ps

module rotated_bitmap_row_blit_unit_tb;
	import rbb_pkg::*;

	localparam int RESET_CYCLES    = 7;
	localparam int IDLE_LIMIT      = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 2 * DEF_MAX_WIDTH + 8;
	localparam int RANDOM_PHASES   = 10;
	localparam int ROWS_PER_PHASE  = 40;
	localparam int SQUEEZE_PHASE   = 1;

	// Byte address of register index 5, which does not exist.
	localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 5'd20;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              row_valid;
	logic              row_stall;
	row_item_t         row;
	logic              pixel_valid;
	logic              pixel_stall;
	pixel_item_t       pixel;

	int pixels_due;
	int fail_count;
	int idle_cycles;
	bit hold_off_req;
	bit steady_rows;

	rotated_bitmap_row_blit_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.row_valid   (row_valid),
		.row_stall   (row_stall),
		.row         (row),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel)
	);

	rbb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.row_valid   (row_valid),
		.row_stall   (row_stall),
		.row         (row),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.pixels_due  (pixels_due),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [ADDR_W-1:0] reg_addr(input reg_idx_t idx);
		return {idx, 2'b00};
	endfunction

	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Bits above the register width are filled with noise; the block must drop them.
	task automatic write_reg(input reg_idx_t idx, input int value, input int bits);
		logic [DATA_W-1:0] d;
		d = $urandom;
		d = (d << bits) | DATA_W'(value);
		apb_access(1'b1, reg_addr(idx), d);
	endtask

	task automatic read_back();
		for (int i = REG_ORIGIN_X; i <= REG_ROTATION; i++)
			apb_access(1'b0, reg_addr(reg_idx_t'(i)), DATA_W'($urandom));
	endtask

	task automatic set_config(input int ox, input int oy, input int w, input int h,
			input rot_t rot);
		write_reg(REG_ORIGIN_X, ox, 8);
		write_reg(REG_ORIGIN_Y, oy, 8);
		write_reg(REG_BITMAP_WIDTH, w, 5);
		write_reg(REG_BITMAP_HEIGHT, h, 8);
		write_reg(REG_ROTATION, int'(rot), 2);
		read_back();
	endtask

	task automatic send_row(input logic [7:0] idx, input logic [15:0] bits);
		int gap;
		int pick;
		gap = 0;
		if (!steady_rows) begin
			pick = $urandom_range(0, 99);
			if (pick >= 90)
				gap = $urandom_range(6, 30);
			else if (pick >= 55)
				gap = $urandom_range(1, 3);
		end
		@(negedge clk);
		if (gap > 0) begin
			row_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_valid <= 1'b1;
		row       <= '{row_index: idx, row_bits: bits};
		@(posedge clk);
		while (row_stall) @(posedge clk);
	endtask

	// Waits until every pixel word is out, then lets a row that yields nothing finish.
	task automatic settle();
		@(negedge clk);
		row_valid <= 1'b0;
		while (pixels_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : pixel_backpressure
		int len;
		int pick;
		pixel_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				pixel_stall <= 1'b1;
				len = HOLD_OFF_CYCLES;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					pixel_stall <= 1'b0;
					len = $urandom_range(1, 4);
				end else if (pick < 85) begin
					pixel_stall <= 1'b1;
					len = $urandom_range(1, 3);
				end else if (pick < 95) begin
					pixel_stall <= 1'b1;
					len = $urandom_range(5, 40);
				end else begin
					pixel_stall <= 1'b0;
					len = $urandom_range(20, 80);
				end
			end
			repeat (len) @(negedge clk);
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || psel || (row_valid && !row_stall) || (pixel_valid && !pixel_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int          pick;
		int          ox, oy, w, h;
		logic [7:0]  idx;
		logic [15:0] bits;

		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		row_valid = 1'b0;
		row       = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: 8 by 8, no rotation, origin at zero.
		read_back();
		send_row(8'd0, 16'h00FF);
		send_row(8'd7, 16'h0081);
		send_row(8'd8, 16'h00FF);
		send_row(8'd255, 16'hFFFF);
		send_row(8'd3, 16'h0000);
		send_row(8'd2, 16'hFF00);
		send_row(8'd5, 16'h0010);

		settle();
		set_config(255, 255, 16, 255, ROT_90);
		send_row(8'd0, 16'hFFFF);
		send_row(8'd254, 16'h8001);
		send_row(8'd255, 16'hFFFF);

		settle();
		set_config(0, 255, 16, 1, ROT_180);
		send_row(8'd0, 16'hFFFF);
		send_row(8'd1, 16'h0001);
		send_row(8'd0, 16'h8000);

		settle();
		set_config(255, 0, 1, 255, ROT_270);
		send_row(8'd254, 16'h0001);
		send_row(8'd0, 16'hFFFE);

		// Widths of zero or past the maximum, and a zero height, draw nothing.
		settle();
		set_config(128, 64, 0, 8, ROT_0);
		send_row(8'd0, 16'hFFFF);
		settle();
		set_config(0, 0, DEF_MAX_WIDTH + 1, 8, ROT_0);
		send_row(8'd1, 16'hFFFF);
		settle();
		set_config(0, 0, 31, 8, ROT_90);
		send_row(8'd1, 16'hFFFF);
		settle();
		set_config(10, 20, 12, 0, ROT_270);
		send_row(8'd0, 16'hFFFF);

		// A write to an address with no register behind it must change nothing.
		settle();
		set_config(3, 7, 12, 9, ROT_0);
		apb_access(1'b1, UNMAPPED_ADDR, DATA_W'($urandom));
		read_back();
		send_row(8'd8, 16'hFFFF);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				w = 0;
			else if (pick == 1)
				w = $urandom_range(DEF_MAX_WIDTH + 1, 31);
			else if (pick < 5)
				w = DEF_MAX_WIDTH;
			else
				w = $urandom_range(1, DEF_MAX_WIDTH);
			pick = $urandom_range(0, 19);
			if (pick == 0)
				h = 0;
			else if (pick == 1)
				h = 255;
			else if (pick < 6)
				h = $urandom_range(1, 4);
			else
				h = $urandom_range(1, 255);
			ox = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 255);
			oy = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(0, 255);
			if (ph == SQUEEZE_PHASE) begin
				w = DEF_MAX_WIDTH;
				h = 255;
			end

			settle();
			set_config(ox, oy, w, h, rot_t'($urandom_range(0, 3)));
			steady_rows = ($urandom_range(0, 3) == 0);
			// The pixel side holds off for a long stretch while rows keep coming.
			if (ph == SQUEEZE_PHASE)
				hold_off_req = 1'b1;

			for (int i = 0; i < ROWS_PER_PHASE; i++) begin
				if (h != 0 && $urandom_range(0, 99) < 85)
					idx = 8'($urandom_range(0, h - 1));
				else
					idx = 8'($urandom_range(0, 255));
				case ($urandom_range(0, 9))
					0: bits = '0;
					1: bits = '1;
					2, 3: bits = 16'(1) << $urandom_range(0, 15);
					default: bits = 16'($urandom);
				endcase
				send_row(idx, bits);
			end
		end

		settle();
		if (fail_count == 0 && pixels_due == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
